/* rtl/bsa_pkg.sv */
// shared types and constants of the bitmap slot allocator
`timescale 1ns / 1ps

package bsa_pkg;

  localparam int DEF_WORD_BITS  = 64;
  localparam int DEF_MAP_WORDS  = 256;
  localparam int DEF_PAGE_BYTES = 131072;

  localparam int SLOT_COUNT_W = 15;
  localparam int OBJ_SIZE_W   = 7;
  localparam int OFFSET_W     = 17;
  localparam int INDEX_W      = 14;

  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;

  localparam logic [OBJ_SIZE_W-1:0] OBJ_SIZE_RESET = 7'd8;

  localparam logic REG_SLOT_COUNT  = 1'b0;
  localparam logic REG_OBJECT_SIZE = 1'b1;

  typedef enum logic [1:0] {
    OP_ALLOC,
    OP_FREE,
    OP_INIT,
    OP_NONE
  } opcode_e;

  typedef enum logic [2:0] {
    STATUS_OK,
    STATUS_FULL,
    STATUS_DOUBLE_FREE,
    STATUS_OUT_OF_RANGE,
    STATUS_MISALIGNED
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_A_READ,
    S_A_SCAN,
    S_A_TAKE,
    S_F_DIV,
    S_F_MUL,
    S_F_SPLIT,
    S_F_FIX,
    S_F_TEST,
    S_I_DIV,
    S_I_LIMIT,
    S_I_FILL,
    S_RESP
  } state_e;

  typedef struct packed {
    opcode_e             opcode;
    logic [OFFSET_W-1:0] free_offset;
  } in_item_t;

  typedef struct packed {
    status_e                 status;
    logic [INDEX_W-1:0]      slot_index;
    logic [OFFSET_W-1:0]     byte_offset;
    logic [SLOT_COUNT_W-1:0] free_slots;
  } out_item_t;

endpackage

/* rtl/bsa_ram.sv */
// generic single write port ram with registered read
`timescale 1ns / 1ps

module bsa_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 256,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/bsa_div.sv */
// radix-2 restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps

module bsa_div #(
  parameter int DIV_W = 18,
  parameter int DSR_W = 7
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [DIV_W-1:0] dividend_i,
  input  logic [DSR_W-1:0] divisor_i,
  output logic             done_o,
  output logic [DIV_W-1:0] quotient_o,
  output logic [DSR_W-1:0] remainder_o
);

  localparam int CW = $clog2(DIV_W + 1);

  logic [CW-1:0]    cnt_q;
  logic             done_q;
  logic [DIV_W-1:0] quo_q;
  logic [DSR_W-1:0] rem_q;
  logic [DSR_W:0]   trial;
  logic [DSR_W:0]   diff;
  logic             fits;

  assign trial = {rem_q, quo_q[DIV_W-1]};
  assign fits  = (trial >= {1'b0, divisor_i});
  assign diff  = trial - {1'b0, divisor_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else if (start_i) begin
      cnt_q  <= CW'(DIV_W);
      done_q <= 1'b0;
    end else if (cnt_q != '0) begin
      cnt_q  <= cnt_q - 1'b1;
      done_q <= (cnt_q == CW'(1));
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
    end else if (cnt_q != '0) begin
      quo_q <= {quo_q[DIV_W-2:0], fits};
      rem_q <= fits ? diff[DSR_W-1:0] : trial[DSR_W-1:0];
    end
  end

  assign done_o      = done_q;
  assign quotient_o  = quo_q;
  assign remainder_o = rem_q;

endmodule

/* rtl/bitmap_slot_allocator.sv */
// bitmap slot allocator top level: sequencer, free map and config registers
//
//   channel | direction | handshake            | payload
//   --------+-----------+----------------------+-----------------------------
//   in      | in        | in_valid_i/in_stall_o | in_item_i (opcode, offset)
//   out     | out       | out_valid_o/out_stall_i | out_item_o (result)
//   cfg     | in        | psel/penable/pwrite  | paddr, pwdata, prdata
//
// one item at a time; a result leaves through an output register
// allocate: scans bitmap words for a free bit (one ram read per cycle)
// free: the bit-serial divider (DIV_W = 18) finds the slot, then its map bit is tested and set
// initialize: divider, then slot limit, then one map word written per cycle
// a stalled result holds the sequencer in its response state
// reset clears control state; map words are written by initialize before use
`timescale 1ns / 1ps

module bitmap_slot_allocator #(
  parameter int WORD_BITS  = bsa_pkg::DEF_WORD_BITS,
  parameter int MAP_WORDS  = bsa_pkg::DEF_MAP_WORDS,
  parameter int PAGE_BYTES = bsa_pkg::DEF_PAGE_BYTES
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  bsa_pkg::in_item_t               in_item_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output bsa_pkg::out_item_t              out_item_o,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [bsa_pkg::CFG_ADDR_W-1:0]  paddr,
  input  logic [bsa_pkg::CFG_DATA_W-1:0]  pwdata,
  output logic [bsa_pkg::CFG_DATA_W-1:0]  prdata,
  output logic                            pready
);

  import bsa_pkg::*;

  localparam int CNT_W    = SLOT_COUNT_W;
  localparam int WW       = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
  localparam int BIT_W    = $clog2(WORD_BITS);
  localparam int PB_W     = $clog2(PAGE_BYTES + 1);
  localparam int DIV_W    = (PB_W > OFFSET_W) ? PB_W : OFFSET_W;
  localparam int CAPACITY = MAP_WORDS * WORD_BITS;
  localparam int RECIP    = (2 ** CNT_W) / WORD_BITS;

  localparam logic [CNT_W-1:0] WB_C    = CNT_W'(WORD_BITS);
  localparam logic [CNT_W-1:0] RECIP_C = CNT_W'(RECIP);
  localparam logic [31:0]      CAP_C   = 32'(CAPACITY);
  localparam logic [DIV_W-1:0] PAGE_C  = DIV_W'(PAGE_BYTES);

  // configuration registers
  logic [CNT_W-1:0]      slot_count_q;
  logic [OBJ_SIZE_W-1:0] obj_size_q;
  logic                  cfg_we;

  assign cfg_we = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_count_q <= '0;
      obj_size_q   <= OBJ_SIZE_RESET;
    end else if (cfg_we) begin
      unique case (paddr[2])
        REG_SLOT_COUNT:  slot_count_q <= pwdata[CNT_W-1:0];
        REG_OBJECT_SIZE: obj_size_q   <= pwdata[OBJ_SIZE_W-1:0];
        default:         ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_SLOT_COUNT:  prdata = CFG_DATA_W'(slot_count_q);
      REG_OBJECT_SIZE: prdata = CFG_DATA_W'(obj_size_q);
      default:         prdata = '0;
    endcase
  end

  // state
  state_e                state_q, state_d;
  logic [WW-1:0]         search_q, search_d;
  logic [CNT_W-1:0]      free_count_q, free_count_d;
  logic [CNT_W-1:0]      limit_q, limit_d;
  logic [WW:0]           used_q, used_d;
  logic                  out_valid_q, out_valid_d;
  out_item_t             out_q, out_d;

  logic [WW-1:0]         scan_q, scan_d;
  logic [WW:0]           steps_q, steps_d;
  logic [WORD_BITS-1:0]  word_q, word_d;
  status_e               res_status_q, res_status_d;
  logic [CNT_W-1:0]      res_slot_q, res_slot_d;
  logic                  res_mul_q, res_mul_d;
  logic [2*CNT_W-1:0]    prod_q, prod_d;
  logic [CNT_W-1:0]      wq_q, wq_d;
  logic [CNT_W-1:0]      rq_q, rq_d;
  logic [WW-1:0]         widx_q, widx_d;
  logic [BIT_W-1:0]      bidx_q, bidx_d;
  logic [CNT_W-1:0]      fill_left_q, fill_left_d;

  // memory and divider hookup
  logic                  ram_we;
  logic [WW-1:0]         ram_waddr;
  logic [WORD_BITS-1:0]  ram_wdata;
  logic [WW-1:0]         ram_raddr;
  logic [WORD_BITS-1:0]  ram_rdata;
  logic                  div_start;
  logic [DIV_W-1:0]      div_dividend;
  logic                  div_done;
  logic [DIV_W-1:0]      div_quo;
  logic [OBJ_SIZE_W-1:0] div_rem;

  bsa_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (MAP_WORDS),
    .AW    (WW)
  ) u_map (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  bsa_div #(
    .DIV_W (DIV_W),
    .DSR_W (OBJ_SIZE_W)
  ) u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (div_start),
    .dividend_i  (div_dividend),
    .divisor_i   (obj_size_q),
    .done_o      (div_done),
    .quotient_o  (div_quo),
    .remainder_o (div_rem)
  );

  // datapath helpers
  logic                          accept;
  logic [WW:0]                   scan_inc;
  logic [WW-1:0]                 scan_next;
  logic [WW-1:0]                 start_word;
  logic [WORD_BITS-1:0]          low_iso;
  logic [WORD_BITS-1:0]          clr_word;
  logic [BIT_W-1:0]              low_bit;
  logic [CNT_W-1:0]              cap_lim;
  logic [CNT_W-1:0]              init_lim;
  logic [WORD_BITS-1:0]          fill_mask;
  logic [WORD_BITS-1:0]          set_mask;
  logic [CNT_W-1:0]              fix_w;
  logic [CNT_W-1:0]              fix_b;
  logic [CNT_W+OBJ_SIZE_W-1:0]   boff_full;

  assign accept     = in_valid_i && (state_q == S_IDLE);
  assign in_stall_o = (state_q != S_IDLE);

  assign scan_inc   = {1'b0, scan_q} + 1'b1;
  assign scan_next  = (scan_inc >= used_q) ? '0 : scan_inc[WW-1:0];
  assign start_word = ({1'b0, search_q} < used_q) ? search_q : '0;

  // lowest free bit: isolate with two's complement, then encode
  assign low_iso  = word_q & (~word_q + 1'b1);
  assign clr_word = word_q & (word_q - 1'b1);

  always_comb begin
    low_bit = '0;
    for (int k = 0; k < WORD_BITS; k++) begin
      if (low_iso[k]) begin
        low_bit = low_bit | BIT_W'(k);
      end
    end
  end

  assign cap_lim  = (32'(slot_count_q) > CAP_C) ? CNT_W'(CAPACITY) : slot_count_q;
  assign init_lim = ((obj_size_q != '0) && (DIV_W'(cap_lim) > div_quo)) ?
                    div_quo[CNT_W-1:0] : cap_lim;

  always_comb begin
    for (int k = 0; k < WORD_BITS; k++) begin
      fill_mask[k] = (CNT_W'(k) < fill_left_q);
      set_mask[k]  = (BIT_W'(k) == bidx_q);
    end
  end

  // word and bit split after the reciprocal estimate
  assign fix_w = (rq_q >= WB_C) ? wq_q + 1'b1 : wq_q;
  assign fix_b = (rq_q >= WB_C) ? rq_q - WB_C : rq_q;

  assign boff_full = res_slot_q * obj_size_q;

  always_comb begin
    state_d      = state_q;
    search_d     = search_q;
    free_count_d = free_count_q;
    limit_d      = limit_q;
    used_d       = used_q;
    out_valid_d  = out_valid_q && out_stall_i;
    out_d        = out_q;
    scan_d       = scan_q;
    steps_d      = steps_q;
    word_d       = word_q;
    res_status_d = res_status_q;
    res_slot_d   = res_slot_q;
    res_mul_d    = res_mul_q;
    prod_d       = prod_q;
    wq_d         = wq_q;
    rq_d         = rq_q;
    widx_d       = widx_q;
    bidx_d       = bidx_q;
    fill_left_d  = fill_left_q;
    ram_we       = 1'b0;
    ram_waddr    = scan_q;
    ram_wdata    = clr_word;
    ram_raddr    = scan_q;
    div_start    = 1'b0;
    div_dividend = DIV_W'(in_item_i.free_offset);

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          res_status_d = STATUS_OK;
          res_slot_d   = '0;
          res_mul_d    = 1'b0;
          unique case (in_item_i.opcode)
            OP_ALLOC: begin
              if (free_count_q == '0) begin
                res_status_d = STATUS_FULL;
                state_d      = S_RESP;
              end else begin
                scan_d  = start_word;
                steps_d = '0;
                state_d = S_A_READ;
              end
            end
            OP_FREE: begin
              if (obj_size_q == '0) begin
                res_status_d = STATUS_MISALIGNED;
                state_d      = S_RESP;
              end else begin
                div_start = 1'b1;
                state_d   = S_F_DIV;
              end
            end
            OP_INIT: begin
              if (obj_size_q == '0) begin
                state_d = S_I_LIMIT;
              end else begin
                div_start    = 1'b1;
                div_dividend = PAGE_C;
                state_d      = S_I_DIV;
              end
            end
            default: begin
              state_d = S_RESP;
            end
          endcase
        end
      end

      S_A_READ: begin
        ram_raddr = scan_q;
        state_d   = S_A_SCAN;
      end

      S_A_SCAN: begin
        ram_raddr = scan_next;
        if (ram_rdata != '0) begin
          word_d  = ram_rdata;
          state_d = S_A_TAKE;
        end else if (steps_q + 1'b1 == used_q) begin
          res_status_d = STATUS_FULL;
          state_d      = S_RESP;
        end else begin
          scan_d  = scan_next;
          steps_d = steps_q + 1'b1;
        end
      end

      S_A_TAKE: begin
        ram_we       = 1'b1;
        ram_waddr    = scan_q;
        ram_wdata    = clr_word;
        free_count_d = free_count_q - 1'b1;
        search_d     = scan_q;
        res_slot_d   = CNT_W'(scan_q) * WB_C + CNT_W'(low_bit);
        res_mul_d    = 1'b1;
        state_d      = S_RESP;
      end

      S_F_DIV: begin
        if (div_done) begin
          res_slot_d = div_quo[CNT_W-1:0];
          if (div_rem != '0) begin
            res_status_d = STATUS_MISALIGNED;
            state_d      = S_RESP;
          end else if (div_quo >= DIV_W'(limit_q)) begin
            res_status_d = STATUS_OUT_OF_RANGE;
            state_d      = S_RESP;
          end else begin
            state_d = S_F_MUL;
          end
        end
      end

      S_F_MUL: begin
        prod_d  = res_slot_q * RECIP_C;
        state_d = S_F_SPLIT;
      end

      S_F_SPLIT: begin
        wq_d    = prod_q[2*CNT_W-1:CNT_W];
        rq_d    = res_slot_q - prod_q[2*CNT_W-1:CNT_W] * WB_C;
        state_d = S_F_FIX;
      end

      S_F_FIX: begin
        widx_d    = fix_w[WW-1:0];
        bidx_d    = fix_b[BIT_W-1:0];
        ram_raddr = fix_w[WW-1:0];
        state_d   = S_F_TEST;
      end

      S_F_TEST: begin
        if (ram_rdata[bidx_q]) begin
          res_status_d = STATUS_DOUBLE_FREE;
        end else begin
          ram_we       = 1'b1;
          ram_waddr    = widx_q;
          ram_wdata    = ram_rdata | set_mask;
          free_count_d = free_count_q + 1'b1;
          search_d     = widx_q;
        end
        state_d = S_RESP;
      end

      S_I_DIV: begin
        if (div_done) begin
          state_d = S_I_LIMIT;
        end
      end

      S_I_LIMIT: begin
        limit_d      = init_lim;
        free_count_d = init_lim;
        fill_left_d  = init_lim;
        search_d     = '0;
        used_d       = '0;
        state_d      = S_I_FILL;
      end

      S_I_FILL: begin
        if (fill_left_q == '0) begin
          state_d = S_RESP;
        end else begin
          ram_we      = 1'b1;
          ram_waddr   = used_q[WW-1:0];
          ram_wdata   = fill_mask;
          used_d      = used_q + 1'b1;
          fill_left_d = (fill_left_q > WB_C) ? fill_left_q - WB_C : '0;
        end
      end

      S_RESP: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d       = 1'b1;
          out_d.status      = res_status_q;
          out_d.slot_index  = res_slot_q[INDEX_W-1:0];
          out_d.byte_offset = res_mul_q ? boff_full[OFFSET_W-1:0] : '0;
          out_d.free_slots  = free_count_q;
          state_d           = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      search_q     <= '0;
      free_count_q <= '0;
      limit_q      <= '0;
      used_q       <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      search_q     <= search_d;
      free_count_q <= free_count_d;
      limit_q      <= limit_d;
      used_q       <= used_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q        <= out_d;
    scan_q       <= scan_d;
    steps_q      <= steps_d;
    word_q       <= word_d;
    res_status_q <= res_status_d;
    res_slot_q   <= res_slot_d;
    res_mul_q    <= res_mul_d;
    prod_q       <= prod_d;
    wq_q         <= wq_d;
    rq_q         <= rq_d;
    widx_q       <= widx_d;
    bidx_q       <= bidx_d;
    fill_left_q  <= fill_left_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule
